@@ rtl/core/grc_pkg.sv @@
// Shared types and constants for the grid ray caster.
// Used by every module of the block but grc_div; no dependencies.
package grc_pkg;

  localparam int unsigned POS_W   = 21;  // Q5.16 position
  localparam int unsigned FRAC_W  = 16;  // fraction bits of a position
  localparam int unsigned DIR_W   = 16;  // Q2.14 direction
  localparam int unsigned Q14_W   = 14;  // fraction bits of a direction
  localparam int unsigned RAY_W   = 18;  // signed ray component
  localparam int unsigned CAM_W   = 16;  // signed Q.14 camera coordinate
  localparam int unsigned CAMN_W  = 11;  // |2*column - screen columns|
  localparam int unsigned DEN_W   = 18;  // divisor width
  localparam int unsigned DIST_W  = 24;  // Q8.16 distance
  localparam int unsigned COL_W   = 10;
  localparam int unsigned CELL_W  = 5;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam int unsigned MAP_DIM_DEF        = 32;
  localparam int unsigned SCREEN_COLUMNS_DEF = 640;
  localparam int unsigned MAX_STEPS_DEF      = 64;

  // input op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // register indexes
  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;

  localparam logic [POS_W-1:0] POS_RST     = 21'd98304;
  localparam logic [DIR_W-1:0] DIR_X_RST   = 16'hC000;
  localparam logic [DIR_W-1:0] DIR_Y_RST   = 16'h0000;
  localparam logic [DIR_W-1:0] PLANE_X_RST = 16'h0000;
  localparam logic [DIR_W-1:0] PLANE_Y_RST = 16'd10813;

  localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [DIR_W-1:0] dir_x;
    logic [DIR_W-1:0] dir_y;
    logic [DIR_W-1:0] plane_x;
    logic [DIR_W-1:0] plane_y;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic cam_load;
    logic ray_x;
    logic ray_y;
    logic init;
    logic mul;
    logic step;
    logic latch_hit;
    logic dist_start;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic cast_ok;
    logic clr_last;
    logic div_busy;
    logic div_done;
    logic start_out;
    logic leave;
    logic hit;
    logic out_free;
  } st_t;

endpackage

@@ rtl/core/grc_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module grc_div #(
  parameter int unsigned NUM_W = 37,
  parameter int unsigned DEN_W = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  // trial subtract
  assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
      num_q <= {num_q[NUM_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

@@ rtl/core/grc_dp.sv @@
// Datapath of the ray caster: map memory, ray setup, grid walk, distance.
// Depends on grc_pkg and grc_div.
module grc_dp #(
  parameter int unsigned MAP_DIM        = grc_pkg::MAP_DIM_DEF,
  parameter int unsigned SCREEN_COLUMNS = grc_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned MAX_STEPS      = grc_pkg::MAX_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  grc_pkg::cfg_t               cfg_i,
  input  grc_pkg::cmd_t               cmd_i,
  output grc_pkg::st_t                st_o,
  input  logic                        in_valid_i,
  input  logic                        op_i,
  input  logic [grc_pkg::COL_W-1:0]   column_i,
  input  logic [grc_pkg::CELL_W-1:0]  cell_row_i,
  input  logic [grc_pkg::CELL_W-1:0]  cell_col_i,
  input  logic [grc_pkg::CODE_W-1:0]  cell_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [grc_pkg::COL_W-1:0]   ray_column_o,
  output logic [grc_pkg::DIST_W-1:0]  wall_distance_o,
  output logic                        hit_side_o,
  output logic [grc_pkg::CELL_W-1:0]  hit_row_o,
  output logic [grc_pkg::CELL_W-1:0]  hit_col_o,
  output logic [grc_pkg::CODE_W-1:0]  wall_code_o,
  output logic                        status_o
);

  localparam int unsigned RW    = grc_pkg::RAY_W;
  localparam int unsigned IW    = $clog2(MAP_DIM);
  localparam int unsigned CW    = IW + 2;
  localparam int unsigned ADW   = $clog2(MAP_DIM * MAP_DIM);
  localparam int unsigned DEPTH = MAP_DIM * MAP_DIM;
  localparam int unsigned TW    = $clog2((MAX_STEPS + 1) * 65536 + 1);
  localparam int unsigned PW    = TW + RW;
  localparam int unsigned NW    = TW + grc_pkg::Q14_W;
  localparam logic [TW-1:0] ONE = TW'(65536);

  // reciprocal of the screen width: exact floor for numerators below 2^25
  localparam int unsigned     RCP_SH = 25 + $clog2(SCREEN_COLUMNS);
  localparam int unsigned     RCP_W  = 27;
  localparam longint unsigned RCP    =
    ((64'd1 << RCP_SH) + 64'(SCREEN_COLUMNS) - 64'd1) / 64'(SCREEN_COLUMNS);
  localparam logic [RCP_W-1:0] RCP_M = RCP_W'(RCP);
  localparam int unsigned     CPW    = grc_pkg::CAMN_W + RCP_W;

  // map memory
  logic [grc_pkg::CODE_W-1:0] mem [DEPTH];
  logic [grc_pkg::CODE_W-1:0] rd_q;
  logic [ADW-1:0]             clr_q, wr_addr, rd_addr;
  logic [grc_pkg::CODE_W-1:0] wr_data;
  logic                       wr_en, wr_ok;

  // ray setup and walk state
  logic                       cam_neg_q;
  logic [grc_pkg::COL_W-1:0]  col_q;
  logic signed [grc_pkg::CAM_W-1:0] cam_q;
  logic signed [31:0]         prod_q, mul_out;
  logic signed [grc_pkg::DIR_W-1:0] mul_a;
  logic signed [RW-1:0]       rx_q, ry, ry_q;
  logic [RW-1:0]              ax_q, ay_q, ay_n;
  logic [TW-1:0]              tx_q, ty_q, tb_q;
  logic [PW-1:0]              px_q, py_q;
  logic signed [CW-1:0]       mx_q, my_q;
  logic                       side_q, skip_q, stat_q;
  logic [grc_pkg::CELL_W-1:0] hr_q, hc_q;
  logic [grc_pkg::CODE_W-1:0] code_q;
  logic [grc_pkg::CAMN_W-1:0] two_c, cam_mag, cam_mag_q;
  logic [CPW-1:0]             cam_prod;
  logic [grc_pkg::CAM_W-1:0]  cam_abs;
  logic                       stepx, mx_out, my_out;
  logic [grc_pkg::FRAC_W-1:0] fx, fy;

  // divider
  logic             div_start, div_busy, div_done;
  logic [NW-1:0]    div_num, div_quo;
  logic [grc_pkg::DEN_W-1:0] div_den;
  logic [grc_pkg::DIST_W-1:0] dist_sat;

  // output register
  logic out_valid_q;

  // -------- map writes, clear sweep and reads
  assign wr_ok   = (32'(cell_row_i) < MAP_DIM) && (32'(cell_col_i) < MAP_DIM);
  assign wr_en   = cmd_i.clear || (cmd_i.accept && op_i == grc_pkg::OP_WRITE && wr_ok);
  assign wr_addr = cmd_i.clear ? clr_q
                 : ADW'(ADW'(cell_row_i) * ADW'(MAP_DIM) + ADW'(cell_col_i));
  assign wr_data = cmd_i.clear ? '0 : cell_value_i;
  assign rd_addr = ADW'(ADW'(mx_q[IW-1:0]) * ADW'(MAP_DIM) + ADW'(my_q[IW-1:0]));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // -------- camera coordinate: |2c - S| * 2^14 / S, sign applied later
  assign two_c   = {column_i, 1'b0};
  assign cam_mag = (32'(two_c) < SCREEN_COLUMNS)
                 ? grc_pkg::CAMN_W'(SCREEN_COLUMNS) - two_c
                 : two_c - grc_pkg::CAMN_W'(SCREEN_COLUMNS);

  // divide by the screen width as a multiply by its reciprocal
  assign cam_prod = CPW'(cam_mag_q) * CPW'(RCP_M);
  assign cam_abs  = grc_pkg::CAM_W'(cam_prod >> (RCP_SH - grc_pkg::Q14_W));

  assign div_start = cmd_i.dist_start;
  assign div_num   = NW'({tb_q, 14'b0});
  assign div_den   = side_q ? ay_q : ax_q;

  grc_div #(.NUM_W(NW), .DEN_W(grc_pkg::DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // -------- shared 16x16 multiplier for plane * cam
  assign mul_a   = cmd_i.ray_x ? $signed(cfg_i.plane_x) : $signed(cfg_i.plane_y);
  assign mul_out = mul_a * cam_q;
  assign ry      = RW'($signed(cfg_i.dir_y)) + RW'(prod_q >>> grc_pkg::Q14_W);
  assign ay_n    = ry[RW-1] ? RW'(-ry) : RW'(ry);
  assign fx      = cfg_i.pos_x[grc_pkg::FRAC_W-1:0];
  assign fy      = cfg_i.pos_y[grc_pkg::FRAC_W-1:0];

  // step choice: exact cross-multiplied compare, ties go to y
  assign stepx  = (ax_q != '0) && ((ay_q == '0) || (px_q < py_q));
  assign mx_out = mx_q[CW-1] || (mx_q >= $signed(CW'(MAP_DIM)));
  assign my_out = my_q[CW-1] || (my_q >= $signed(CW'(MAP_DIM)));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      col_q     <= column_i;
      cam_neg_q <= 32'(two_c) < SCREEN_COLUMNS;
      cam_mag_q <= cam_mag;
    end
    if (cmd_i.cam_load) begin
      cam_q <= cam_neg_q ? -$signed(cam_abs) : $signed(cam_abs);
    end
    if (cmd_i.ray_x || cmd_i.ray_y) begin
      prod_q <= mul_out;
    end
    if (cmd_i.ray_y) begin
      rx_q <= RW'($signed(cfg_i.dir_x)) + RW'(prod_q >>> grc_pkg::Q14_W);
    end
    // start of the walk
    if (cmd_i.init) begin
      ry_q   <= ry;
      ax_q   <= rx_q[RW-1] ? RW'(-rx_q) : RW'(rx_q);
      ay_q   <= ay_n;
      tx_q   <= rx_q[RW-1] ? TW'(fx) : ONE - TW'(fx);
      ty_q   <= ry[RW-1] ? TW'(fy) : ONE - TW'(fy);
      mx_q   <= CW'(cfg_i.pos_x[grc_pkg::POS_W-1:grc_pkg::FRAC_W]);
      my_q   <= CW'(cfg_i.pos_y[grc_pkg::POS_W-1:grc_pkg::FRAC_W]);
      tb_q   <= '0;
      side_q <= 1'b0;
      stat_q <= 1'b1;
      hr_q   <= '0;
      hc_q   <= '0;
      code_q <= '0;
      skip_q <= st_o.start_out;
    end
    if (cmd_i.mul) begin
      px_q <= PW'(tx_q) * PW'(ay_q);
      py_q <= PW'(ty_q) * PW'(ax_q);
    end
    // one boundary crossing
    if (cmd_i.step) begin
      if (stepx) begin
        tb_q   <= tx_q;
        tx_q   <= tx_q + ONE;
        mx_q   <= rx_q[RW-1] ? mx_q - 1'b1 : mx_q + 1'b1;
        side_q <= 1'b0;
      end else begin
        tb_q   <= ty_q;
        ty_q   <= ty_q + ONE;
        my_q   <= ry_q[RW-1] ? my_q - 1'b1 : my_q + 1'b1;
        side_q <= 1'b1;
      end
    end
    if (cmd_i.latch_hit) begin
      stat_q <= 1'b0;
      hr_q   <= grc_pkg::CELL_W'(mx_q[IW-1:0]);
      hc_q   <= grc_pkg::CELL_W'(my_q[IW-1:0]);
      code_q <= rd_q;
    end
  end

  // -------- result register
  assign dist_sat = (div_quo[NW-1:grc_pkg::DIST_W] != '0) ? grc_pkg::DIST_MAX
                  : div_quo[grc_pkg::DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ray_column_o    <= col_q;
      wall_distance_o <= skip_q ? '0 : dist_sat;
      hit_side_o      <= side_q;
      hit_row_o       <= hr_q;
      hit_col_o       <= hc_q;
      wall_code_o     <= code_q;
      status_o        <= stat_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // -------- status to controller
  assign st_o.in_valid  = in_valid_i;
  assign st_o.cast_ok   = (op_i == grc_pkg::OP_CAST) && (32'(column_i) < SCREEN_COLUMNS);
  assign st_o.clr_last  = clr_q == ADW'(DEPTH - 1);
  assign st_o.div_busy  = div_busy;
  assign st_o.div_done  = div_done;
  assign st_o.start_out =
    (32'(cfg_i.pos_x[grc_pkg::POS_W-1:grc_pkg::FRAC_W]) >= MAP_DIM) ||
    (32'(cfg_i.pos_y[grc_pkg::POS_W-1:grc_pkg::FRAC_W]) >= MAP_DIM);
  assign st_o.leave     = mx_out || my_out;
  assign st_o.hit       = rd_q != '0;
  assign st_o.out_free  = !out_valid_q || out_ready_i;

endmodule

@@ rtl/core/grc_ctrl.sv @@
// Sequencer of the ray caster: clear sweep, ray setup, walk loop, distance.
// Depends on grc_pkg; drives grc_dp through cmd_t and reads st_t.
module grc_ctrl #(
  parameter int unsigned MAX_STEPS = grc_pkg::MAX_STEPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  grc_pkg::st_t  st_i,
  output grc_pkg::cmd_t cmd_o,
  output logic          in_ready_o
);

  localparam int unsigned SW = $clog2(MAX_STEPS);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CAM, ST_RX, ST_RY, ST_INIT, ST_MUL, ST_STEP,
    ST_READ, ST_CHECK, ST_DIST, ST_DWAIT, ST_DONE
  } state_e;

  state_e        state_q;
  logic [SW-1:0] n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      n_q     <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: if (st_i.clr_last) state_q <= ST_IDLE;
        ST_IDLE:  if (st_i.in_valid && st_i.cast_ok) state_q <= ST_CAM;
        ST_CAM:   state_q <= ST_RX;
        ST_RX:    state_q <= ST_RY;
        ST_RY:    state_q <= ST_INIT;
        ST_INIT: begin
          n_q     <= '0;
          state_q <= st_i.start_out ? ST_DONE : ST_MUL;
        end
        ST_MUL:   state_q <= ST_STEP;
        ST_STEP:  state_q <= ST_READ;
        // map read in flight; an exit ends the walk here
        ST_READ:  state_q <= st_i.leave ? ST_DIST : ST_CHECK;
        ST_CHECK: begin
          n_q <= n_q + 1'b1;
          if (st_i.hit || n_q == SW'(MAX_STEPS - 1)) begin
            state_q <= ST_DIST;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_DIST:  state_q <= ST_DWAIT;
        ST_DWAIT: if (st_i.div_done) state_q <= ST_DONE;
        ST_DONE:  if (st_i.out_free) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // command decode
  assign in_ready_o       = state_q == ST_IDLE;
  assign cmd_o.clear      = state_q == ST_CLEAR;
  assign cmd_o.accept     = in_ready_o && st_i.in_valid;
  assign cmd_o.cam_load   = state_q == ST_CAM;
  assign cmd_o.ray_x      = state_q == ST_RX;
  assign cmd_o.ray_y      = state_q == ST_RY;
  assign cmd_o.init       = state_q == ST_INIT;
  assign cmd_o.mul        = state_q == ST_MUL;
  assign cmd_o.step       = state_q == ST_STEP;
  assign cmd_o.latch_hit  = state_q == ST_CHECK && st_i.hit;
  assign cmd_o.dist_start = state_q == ST_DIST;
  assign cmd_o.out_load   = state_q == ST_DONE && st_i.out_free;

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.dist_start |-> !st_i.div_busy)
    else $error("distance divide started while divider busy");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> st_i.out_free)
    else $error("result loaded over an untaken word");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> 32'(n_q) < MAX_STEPS)
    else $error("walk went past the step limit");
  a_hit_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ && !st_i.leave |=> state_q == ST_CHECK)
    else $error("in-map read not followed by cell check");

endmodule

@@ rtl/core/grid_ray_caster.sv @@
// Grid ray caster top level: APB registers, controller and datapath.
// Depends on grc_pkg, grc_ctrl, grc_dp (which holds grc_div).
//
// Usage. Input words (valid/ready) carry op, column and a map cell. op write
// stores cell_value at (cell_row, cell_col) and gives no result; op cast
// casts the ray for one screen column and gives one result word (valid/ready)
// with distance, side, cell, code and status. Casts with column out of range
// and writes outside the map are dropped. View registers are written over
// the APB port; the user must do so only while the block is idle, as the
// block itself does not enforce it. Reset: the map is swept to open, one
// cell a cycle, over every cell; no input word is taken during the sweep.
// Order: one item at a time. A cast runs ray setup (camera coordinate by
// reciprocal multiply, two plane products, walk init), then per grid step
// product, step, map read and check (no check for a step that leaves the
// map), then the distance divide, then the result load. When the viewer is
// off the map the walk and divide are skipped. A finished result sits in
// the output register; the next item is accepted meanwhile, but a later
// result waits until the receiver takes the current.
module grid_ray_caster #(
  parameter int unsigned MAP_DIM        = grc_pkg::MAP_DIM_DEF,
  parameter int unsigned SCREEN_COLUMNS = grc_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned MAX_STEPS      = grc_pkg::MAX_STEPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [grc_pkg::COL_W-1:0]    column_i,
  input  logic [grc_pkg::CELL_W-1:0]   cell_row_i,
  input  logic [grc_pkg::CELL_W-1:0]   cell_col_i,
  input  logic [grc_pkg::CODE_W-1:0]   cell_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [grc_pkg::COL_W-1:0]    ray_column_o,
  output logic [grc_pkg::DIST_W-1:0]   wall_distance_o,
  output logic                         hit_side_o,
  output logic [grc_pkg::CELL_W-1:0]   hit_row_o,
  output logic [grc_pkg::CELL_W-1:0]   hit_col_o,
  output logic [grc_pkg::CODE_W-1:0]   wall_code_o,
  output logic                         status_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [grc_pkg::PADDR_W-1:0]  paddr,
  input  logic [grc_pkg::PDATA_W-1:0]  pwdata,
  output logic [grc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  grc_pkg::cfg_t cfg_q;
  grc_pkg::cmd_t cmd;
  grc_pkg::st_t  st;
  logic [2:0]    reg_idx;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x   <= grc_pkg::POS_RST;
      cfg_q.pos_y   <= grc_pkg::POS_RST;
      cfg_q.dir_x   <= grc_pkg::DIR_X_RST;
      cfg_q.dir_y   <= grc_pkg::DIR_Y_RST;
      cfg_q.plane_x <= grc_pkg::PLANE_X_RST;
      cfg_q.plane_y <= grc_pkg::PLANE_Y_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        grc_pkg::REG_POS_X:   cfg_q.pos_x   <= pwdata[grc_pkg::POS_W-1:0];
        grc_pkg::REG_POS_Y:   cfg_q.pos_y   <= pwdata[grc_pkg::POS_W-1:0];
        grc_pkg::REG_DIR_X:   cfg_q.dir_x   <= pwdata[grc_pkg::DIR_W-1:0];
        grc_pkg::REG_DIR_Y:   cfg_q.dir_y   <= pwdata[grc_pkg::DIR_W-1:0];
        grc_pkg::REG_PLANE_X: cfg_q.plane_x <= pwdata[grc_pkg::DIR_W-1:0];
        grc_pkg::REG_PLANE_Y: cfg_q.plane_y <= pwdata[grc_pkg::DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      grc_pkg::REG_POS_X:   prdata = grc_pkg::PDATA_W'(cfg_q.pos_x);
      grc_pkg::REG_POS_Y:   prdata = grc_pkg::PDATA_W'(cfg_q.pos_y);
      grc_pkg::REG_DIR_X:   prdata = grc_pkg::PDATA_W'(cfg_q.dir_x);
      grc_pkg::REG_DIR_Y:   prdata = grc_pkg::PDATA_W'(cfg_q.dir_y);
      grc_pkg::REG_PLANE_X: prdata = grc_pkg::PDATA_W'(cfg_q.plane_x);
      grc_pkg::REG_PLANE_Y: prdata = grc_pkg::PDATA_W'(cfg_q.plane_y);
      default:              prdata = '0;
    endcase
  end

  grc_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .st_i       (st),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  grc_dp #(
    .MAP_DIM        (MAP_DIM),
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .MAX_STEPS      (MAX_STEPS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .st_o            (st),
    .in_valid_i      (in_valid_i),
    .op_i            (op_i),
    .column_i        (column_i),
    .cell_row_i      (cell_row_i),
    .cell_col_i      (cell_col_i),
    .cell_value_i    (cell_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ray_column_o    (ray_column_o),
    .wall_distance_o (wall_distance_o),
    .hit_side_o      (hit_side_o),
    .hit_row_o       (hit_row_o),
    .hit_col_o       (hit_col_o),
    .wall_code_o     (wall_code_o),
    .status_o        (status_o)
  );

endmodule
